// ----- design/mld_pkg.sv -----
// Shared types, constants and helper functions for the MIDI learn detector.
package mld_pkg;

  // Configuration register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_LEARN_ENABLE     = 2'd0;
  localparam logic [1:0] REG_NOTE_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_REPEAT_THRESHOLD = 2'd2;

  // Reset values of the thresholds.
  localparam logic [7:0] NOTE_THRESHOLD_RST   = 8'd2;
  localparam logic [7:0] REPEAT_THRESHOLD_RST = 8'd8;

  // Result kinds, also used as event counter indexes.
  localparam logic [1:0] KIND_NOTE   = 2'd0;
  localparam logic [1:0] KIND_BEND   = 2'd1;
  localparam logic [1:0] KIND_CC_ABS = 2'd2;
  localparam logic [1:0] KIND_CC_REL = 2'd3;

  // MIDI message types (high nibble of the status byte).
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CC       = 4'hB;
  localparam logic [3:0] TYPE_BEND     = 4'hE;

  // Controller number bounds for 14-bit controller (MSB/LSB) pair detection.
  localparam logic [6:0] CTRL_LSB_LOW  = 7'd32;
  localparam logic [6:0] CTRL_LSB_HIGH = 7'd64;

  // Depth of the command and result queues.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [1:0]  QUEUE_FULL  = 2'd2;

  // Message class decided by the front end.
  typedef enum logic [1:0] {
    CLS_NOTE,
    CLS_BEND,
    CLS_CC,
    CLS_OTHER
  } mld_cls_e;

  // One classified message travelling from front end to back end.
  typedef struct packed {
    logic [1:0] port;
    logic [3:0] chan;
    mld_cls_e   cls;
    logic [6:0] number;
    logic       rel;
  } mld_cmd_t;

  // One learned source waiting to be taken.
  typedef struct packed {
    logic [1:0] port;
    logic [3:0] chan;
    logic [1:0] kind;
    logic [6:0] number;
  } mld_res_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic       enable;
    logic [7:0] note_thr;
    logic [7:0] repeat_thr;
    logic       clear;
  } mld_cfg_t;

  // Saturating increment of an event counter.
  function automatic logic [7:0] sat_inc(input logic [7:0] value);
    sat_inc = (value == 8'hFF) ? value : value + 8'd1;
  endfunction

  // A threshold of zero behaves as one.
  function automatic logic [7:0] eff_thr(input logic [7:0] thr);
    eff_thr = (thr == 8'd0) ? 8'd1 : thr;
  endfunction

endpackage

// ----- design/mld_cfg.sv -----
// APB-style configuration registers of the MIDI learn detector.
module mld_cfg
  import mld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output mld_cfg_t    cfg_o
);

  logic       enable_q, enable_d;
  logic [7:0] note_thr_q, note_thr_d;
  logic [7:0] repeat_thr_q, repeat_thr_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register write decode.
  always_comb begin
    enable_d     = enable_q;
    note_thr_d   = note_thr_q;
    repeat_thr_d = repeat_thr_q;
    if (wr_en) begin
      case (reg_idx)
        REG_LEARN_ENABLE:     enable_d     = pwdata[0];
        REG_NOTE_THRESHOLD:   note_thr_d   = pwdata[7:0];
        REG_REPEAT_THRESHOLD: repeat_thr_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      note_thr_q   <= NOTE_THRESHOLD_RST;
      repeat_thr_q <= REPEAT_THRESHOLD_RST;
    end else begin
      enable_q     <= enable_d;
      note_thr_q   <= note_thr_d;
      repeat_thr_q <= repeat_thr_d;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      REG_LEARN_ENABLE:     prdata = {31'd0, enable_q};
      REG_NOTE_THRESHOLD:   prdata = {24'd0, note_thr_q};
      REG_REPEAT_THRESHOLD: prdata = {24'd0, repeat_thr_q};
      default:              prdata = 32'd0;
    endcase
  end

  // Any write to the enable register clears the detector state.
  assign cfg_o.enable     = enable_q;
  assign cfg_o.note_thr   = note_thr_q;
  assign cfg_o.repeat_thr = repeat_thr_q;
  assign cfg_o.clear      = wr_en & (reg_idx == REG_LEARN_ENABLE);

endmodule

// ----- design/mld_front.sv -----
// Front end: accepts MIDI messages, classifies them and queues them for the back end.
module mld_front
  import mld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] port_id_i,
  input  logic [7:0] status_byte_i,
  input  logic [6:0] data_one_i,
  input  logic [6:0] data_two_i,
  input  logic       learn_enable_i,
  output logic       cmd_valid_o,
  output mld_cmd_t   cmd_o,
  input  logic       cmd_take_i
);

  mld_cmd_t   entries_q [QUEUE_DEPTH];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  logic       wr_en;
  logic       rd_en;
  mld_cmd_t   cmd_new;

  assign full        = (cnt_q == QUEUE_FULL);
  assign accept      = push & ~full;
  // Messages taken while disabled, or without a status bit, are dropped here.
  assign wr_en       = accept & learn_enable_i & status_byte_i[7];
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign rd_en       = cmd_take_i & cmd_valid_o;

  // Classify the message by its type nibble and its controller value.
  always_comb begin
    cmd_new.port   = port_id_i;
    cmd_new.chan   = status_byte_i[3:0];
    cmd_new.number = data_one_i;
    cmd_new.rel    = data_two_i inside {[7'd1:7'd7], [7'd65:7'd71]};
    case (status_byte_i[7:4])
      TYPE_NOTE_OFF: cmd_new.cls = CLS_NOTE;
      TYPE_NOTE_ON:  cmd_new.cls = CLS_NOTE;
      TYPE_BEND:     cmd_new.cls = CLS_BEND;
      TYPE_CC:       cmd_new.cls = CLS_CC;
      default:       cmd_new.cls = CLS_OTHER;
    endcase
  end

  // Queue pointers and fill count.
  always_comb begin
    wptr_d = wr_en ? ~wptr_q : wptr_q;
    rptr_d = rd_en ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wptr_q] <= cmd_new;
    end
  end

  assign cmd_o = entries_q[rptr_q];

  // The fill count never passes the queue depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_FULL)
    else $error("command queue overfilled");

  // A write into a full queue cannot happen.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !wr_en)
    else $error("write into full command queue");

  // Pointers differ exactly when the queue is partly filled.
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) == (wptr_q != rptr_q))
    else $error("queue pointers disagree with fill count");

endmodule

// ----- design/mld_back.sv -----
// Back end: tracks the source, counts events, decides results and queues them.
module mld_back
  import mld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  mld_cmd_t   cmd_i,
  output logic       cmd_take_o,
  input  mld_cfg_t   cfg_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] learned_port_o,
  output logic [3:0] learned_channel_o,
  output logic [1:0] learned_kind_o,
  output logic [6:0] learned_number_o
);

  // Tracking state.
  logic            src_valid_q, src_valid_d;
  logic [1:0]      src_port_q, src_port_d;
  logic [3:0]      src_chan_q, src_chan_d;
  logic            note_valid_q, note_valid_d;
  logic [6:0]      note_num_q, note_num_d;
  logic            ctrl_valid_q, ctrl_valid_d;
  logic [6:0]      ctrl_num_q, ctrl_num_d;
  logic            prev_valid_q, prev_valid_d;
  logic [6:0]      prev_num_q, prev_num_d;
  logic [3:0][7:0] cnt_q, cnt_d;

  // Values after the source check.
  logic            src_chg;
  logic            b_note_valid, b_ctrl_valid, b_prev_valid;
  logic [6:0]      b_note_num, b_ctrl_num, b_prev_num;
  logic [3:0][7:0] b_cnt;

  // Next values after the message is applied.
  logic            n_note_valid, n_ctrl_valid, n_prev_valid;
  logic [6:0]      n_note_num, n_ctrl_num, n_prev_num;
  logic [3:0][7:0] n_cnt;
  logic            pair;
  logic [7:0]      note_thr, rep_thr;
  logic            hit;
  mld_res_t        res_new;

  // Result queue.
  mld_res_t        res_q [QUEUE_DEPTH];
  logic            rwptr_q, rwptr_d;
  logic            rrptr_q, rrptr_d;
  logic [1:0]      rcnt_q, rcnt_d;
  logic            res_wr, res_rd;
  mld_res_t        res_out;

  assign cmd_take_o = cmd_valid_i & (rcnt_q != QUEUE_FULL);

  // A change of port or channel starts again from a cleared state.
  always_comb begin
    src_chg      = !src_valid_q || (cmd_i.port != src_port_q) || (cmd_i.chan != src_chan_q);
    b_note_valid = src_chg ? 1'b0 : note_valid_q;
    b_note_num   = src_chg ? 7'd0 : note_num_q;
    b_ctrl_valid = src_chg ? 1'b0 : ctrl_valid_q;
    b_ctrl_num   = src_chg ? 7'd0 : ctrl_num_q;
    b_prev_valid = src_chg ? 1'b0 : prev_valid_q;
    b_prev_num   = src_chg ? 7'd0 : prev_num_q;
    b_cnt        = src_chg ? '0 : cnt_q;
  end

  // Apply the message to the note, controller and counter state.
  always_comb begin
    n_note_valid = b_note_valid;
    n_note_num   = b_note_num;
    n_ctrl_valid = b_ctrl_valid;
    n_ctrl_num   = b_ctrl_num;
    n_prev_valid = b_prev_valid;
    n_prev_num   = b_prev_num;
    n_cnt        = b_cnt;
    pair         = 1'b0;
    case (cmd_i.cls)
      CLS_NOTE: begin
        if (!b_note_valid || (cmd_i.number != b_note_num)) begin
          n_cnt[KIND_NOTE] = 8'd0;
          n_note_valid     = 1'b1;
          n_note_num       = cmd_i.number;
        end
        n_cnt[KIND_NOTE] = sat_inc(n_cnt[KIND_NOTE]);
      end
      CLS_BEND: begin
        n_cnt[KIND_BEND] = sat_inc(b_cnt[KIND_BEND]);
      end
      CLS_CC: begin
        // The low half of a 14-bit controller pair directly after its high half is not counted.
        pair = b_prev_valid && (b_prev_num < CTRL_LSB_LOW) &&
               (cmd_i.number >= CTRL_LSB_LOW) && (cmd_i.number < CTRL_LSB_HIGH);
        n_prev_valid = 1'b1;
        n_prev_num   = cmd_i.number;
        if (!pair) begin
          if (!b_ctrl_valid || (cmd_i.number != b_ctrl_num)) begin
            n_cnt[KIND_CC_ABS] = 8'd0;
            n_cnt[KIND_CC_REL] = 8'd0;
            n_ctrl_valid       = 1'b1;
            n_ctrl_num         = cmd_i.number;
          end
          if (cmd_i.rel) begin
            n_cnt[KIND_CC_REL] = sat_inc(n_cnt[KIND_CC_REL]);
          end else begin
            n_cnt[KIND_CC_ABS] = sat_inc(n_cnt[KIND_CC_ABS]);
          end
        end
      end
      default: ;
    endcase
  end

  // Threshold check in priority order: note, pitch bend, absolute, relative.
  always_comb begin
    note_thr       = eff_thr(cfg_i.note_thr);
    rep_thr        = eff_thr(cfg_i.repeat_thr);
    hit            = (cmd_i.cls != CLS_OTHER);
    res_new.port   = cmd_i.port;
    res_new.chan   = cmd_i.chan;
    res_new.kind   = KIND_NOTE;
    res_new.number = n_note_num;
    if (n_cnt[KIND_NOTE] >= note_thr) begin
      res_new.kind   = KIND_NOTE;
      res_new.number = n_note_num;
    end else if (n_cnt[KIND_BEND] >= rep_thr) begin
      res_new.kind   = KIND_BEND;
      res_new.number = 7'd0;
    end else if (n_cnt[KIND_CC_ABS] >= rep_thr) begin
      res_new.kind   = KIND_CC_ABS;
      res_new.number = n_ctrl_num;
    end else if (n_cnt[KIND_CC_REL] >= rep_thr) begin
      res_new.kind   = KIND_CC_REL;
      res_new.number = n_ctrl_num;
    end else begin
      hit = 1'b0;
    end
  end

  // Next state: cleared by an enable write or a result, else updated by a taken message.
  always_comb begin
    src_valid_d  = src_valid_q;
    src_port_d   = src_port_q;
    src_chan_d   = src_chan_q;
    note_valid_d = note_valid_q;
    note_num_d   = note_num_q;
    ctrl_valid_d = ctrl_valid_q;
    ctrl_num_d   = ctrl_num_q;
    prev_valid_d = prev_valid_q;
    prev_num_d   = prev_num_q;
    cnt_d        = cnt_q;
    if (cfg_i.clear || (cmd_take_o && hit)) begin
      src_valid_d  = 1'b0;
      src_port_d   = 2'd0;
      src_chan_d   = 4'd0;
      note_valid_d = 1'b0;
      note_num_d   = 7'd0;
      ctrl_valid_d = 1'b0;
      ctrl_num_d   = 7'd0;
      prev_valid_d = 1'b0;
      prev_num_d   = 7'd0;
      cnt_d        = '0;
    end else if (cmd_take_o) begin
      src_valid_d  = 1'b1;
      src_port_d   = cmd_i.port;
      src_chan_d   = cmd_i.chan;
      note_valid_d = n_note_valid;
      note_num_d   = n_note_num;
      ctrl_valid_d = n_ctrl_valid;
      ctrl_num_d   = n_ctrl_num;
      prev_valid_d = n_prev_valid;
      prev_num_d   = n_prev_num;
      cnt_d        = n_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid_q  <= 1'b0;
      src_port_q   <= 2'd0;
      src_chan_q   <= 4'd0;
      note_valid_q <= 1'b0;
      note_num_q   <= 7'd0;
      ctrl_valid_q <= 1'b0;
      ctrl_num_q   <= 7'd0;
      prev_valid_q <= 1'b0;
      prev_num_q   <= 7'd0;
      cnt_q        <= '0;
    end else begin
      src_valid_q  <= src_valid_d;
      src_port_q   <= src_port_d;
      src_chan_q   <= src_chan_d;
      note_valid_q <= note_valid_d;
      note_num_q   <= note_num_d;
      ctrl_valid_q <= ctrl_valid_d;
      ctrl_num_q   <= ctrl_num_d;
      prev_valid_q <= prev_valid_d;
      prev_num_q   <= prev_num_d;
      cnt_q        <= cnt_d;
    end
  end

  // Result queue control.
  assign res_wr = cmd_take_o & hit;
  assign empty  = (rcnt_q == 2'd0);
  assign res_rd = pop & ~empty;

  always_comb begin
    rwptr_d = res_wr ? ~rwptr_q : rwptr_q;
    rrptr_d = res_rd ? ~rrptr_q : rrptr_q;
    rcnt_d  = rcnt_q + {1'b0, res_wr} - {1'b0, res_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwptr_q <= 1'b0;
      rrptr_q <= 1'b0;
      rcnt_q  <= 2'd0;
    end else begin
      rwptr_q <= rwptr_d;
      rrptr_q <= rrptr_d;
      rcnt_q  <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_q[rwptr_q] <= res_new;
    end
  end

  assign res_out           = res_q[rrptr_q];
  assign learned_port_o    = res_out.port;
  assign learned_channel_o = res_out.chan;
  assign learned_kind_o    = res_out.kind;
  assign learned_number_o  = res_out.number;

  // A result always leaves the tracking state cleared.
  a_clear_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |=> !src_valid_q && (cnt_q == '0))
    else $error("state not cleared after a result");

  // The result queue never overfills.
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= QUEUE_FULL)
    else $error("result queue overfilled");

  // Counters are only non-zero while a source is tracked.
  a_cnt_needs_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !src_valid_q |-> (cnt_q == '0))
    else $error("event counter set without a tracked source");

endmodule

// ----- design/midi_learn_detector_top.sv -----
// Top level of the MIDI learn detector: configuration port, front end and back end.
// The detector takes one MIDI channel message per clock cycle while full is low, through
// a queue-style push/full port and presents learned sources on a pop/empty port. A message
// passes through a two-entry command queue in the front end, is applied to the tracking
// state when the back end takes it, and any result is registered into a two-entry result
// queue. The sustained rate is one message per cycle; the back end pauses only while
// the result queue is full, and the front end then keeps taking messages until its own
// queue fills. Configuration is written through the APB-style port while no messages
// are in flight.
module midi_learn_detector_top
  import mld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Message input.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  port_id_i,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  data_one_i,
  input  logic [6:0]  data_two_i,
  // Result output.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  learned_port_o,
  output logic [3:0]  learned_channel_o,
  output logic [1:0]  learned_kind_o,
  output logic [6:0]  learned_number_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mld_cfg_t cfg;
  logic     cmd_valid;
  mld_cmd_t cmd;
  logic     cmd_take;

  // Configuration registers.
  mld_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Message acceptance and classification.
  mld_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .port_id_i      (port_id_i),
    .status_byte_i  (status_byte_i),
    .data_one_i     (data_one_i),
    .data_two_i     (data_two_i),
    .learn_enable_i (cfg.enable),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_take_i     (cmd_take)
  );

  // Tracking, counting and result generation.
  mld_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_take_o        (cmd_take),
    .cfg_i             (cfg),
    .empty             (empty),
    .pop               (pop),
    .learned_port_o    (learned_port_o),
    .learned_channel_o (learned_channel_o),
    .learned_kind_o    (learned_kind_o),
    .learned_number_o  (learned_number_o)
  );

endmodule
